// ----- design/tplc_pkg.sv -----
package tplc_pkg;

   // Pump operating mode, as reported on the mode field
   typedef enum logic [1:0] {
      MODE_OFF = 2'd0,
      MODE_ON  = 2'd1,
      MODE_ERR = 2'd2
   } mode_type;

   // Error lamp blink phase
   typedef enum logic [1:0] {
      LAMP_IDLE = 2'd0,
      LAMP_LIT  = 2'd1,
      LAMP_DARK = 2'd2
   } lamp_type;

   // Event formed each tick from the sensor samples and the guard timer
   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_LOW   = 2'd1,
      EV_HIGH  = 2'd2,
      EV_ERROR = 2'd3
   } event_type;

   localparam int unsigned TICK_W = 16;
   localparam logic [TICK_W-1:0] TICK_MAX = '1;
   localparam logic [TICK_W-1:0] GUARD_TIMEOUT_RST = 16'd1000;
   localparam logic [TICK_W-1:0] BLINK_PERIOD_RST = 16'd500;

   // Register indexes on the configuration port
   localparam logic [0:0] CSR_GUARD_TIMEOUT = 1'b0;
   localparam logic [0:0] CSR_BLINK_PERIOD  = 1'b1;

   // Controller state carried from tick to tick
   typedef struct packed {
      mode_type          pump_mode;
      logic              fault_flag;
      logic              prev_below_low;
      logic              prev_above_high;
      logic              guard_armed;
      logic [TICK_W-1:0] guard_ticks;
      lamp_type          lamp_phase;
      logic [TICK_W-1:0] blink_ticks;
   } ctrl_state_type;

endpackage

// ----- design/tplc_step.sv -----
module tplc_step (
   input  tplc_pkg::ctrl_state_type   cur,
   input  logic                       below_low_mark,
   input  logic                       above_high_mark,
   input  logic [tplc_pkg::TICK_W-1:0] guard_timeout,
   input  logic [tplc_pkg::TICK_W-1:0] blink_period,
   output tplc_pkg::ctrl_state_type   nxt,
   output logic                       pump_drive,
   output logic                       error_lamp,
   output logic [1:0]                 mode,
   output logic                       fault_latched
);

   tplc_pkg::event_type ev;

   always_comb begin
      nxt = cur;
      ev  = tplc_pkg::EV_NONE;

      // advance the running counters, saturating
      if (cur.guard_armed && cur.guard_ticks != tplc_pkg::TICK_MAX) begin
         nxt.guard_ticks = cur.guard_ticks + 1'b1;
      end
      if ((cur.lamp_phase == tplc_pkg::LAMP_LIT || cur.lamp_phase == tplc_pkg::LAMP_DARK)
          && cur.blink_ticks != tplc_pkg::TICK_MAX) begin
         nxt.blink_ticks = cur.blink_ticks + 1'b1;
      end

      // lower sensor edge wins, then upper, then guard expiry
      priority if (below_low_mark != cur.prev_below_low) begin
         if (below_low_mark) begin
            ev = above_high_mark ? tplc_pkg::EV_ERROR : tplc_pkg::EV_LOW;
         end
      end else if (above_high_mark != cur.prev_above_high) begin
         if (above_high_mark) begin
            ev = below_low_mark ? tplc_pkg::EV_ERROR : tplc_pkg::EV_HIGH;
         end
      end else if (nxt.guard_armed && nxt.guard_ticks >= guard_timeout) begin
         nxt.guard_armed = 1'b0;
         nxt.guard_ticks = '0;
         ev = tplc_pkg::EV_ERROR;
      end else begin
         // quiet tick: no event
      end
      nxt.prev_below_low  = below_low_mark;
      nxt.prev_above_high = above_high_mark;

      // pump mode
      unique case (cur.pump_mode)
         tplc_pkg::MODE_OFF: begin
            if (ev == tplc_pkg::EV_LOW) begin
               nxt.pump_mode   = tplc_pkg::MODE_ON;
               nxt.guard_armed = 1'b1;
               nxt.guard_ticks = '0;
            end else if (ev == tplc_pkg::EV_ERROR) begin
               nxt.pump_mode   = tplc_pkg::MODE_ERR;
               nxt.fault_flag  = 1'b1;
               nxt.guard_armed = 1'b0;
               nxt.guard_ticks = '0;
            end
         end
         tplc_pkg::MODE_ON: begin
            if (ev == tplc_pkg::EV_ERROR) begin
               nxt.pump_mode   = tplc_pkg::MODE_ERR;
               nxt.fault_flag  = 1'b1;
               nxt.guard_armed = 1'b0;
               nxt.guard_ticks = '0;
            end else if (ev == tplc_pkg::EV_HIGH) begin
               nxt.pump_mode   = tplc_pkg::MODE_OFF;
               nxt.guard_armed = 1'b0;
               nxt.guard_ticks = '0;
            end
         end
         default: begin
            // error and the unused code hold
         end
      endcase

      // lamp blink, sees this tick's fault flag
      unique case (cur.lamp_phase)
         tplc_pkg::LAMP_IDLE: begin
            if (nxt.fault_flag) begin
               nxt.lamp_phase  = tplc_pkg::LAMP_LIT;
               nxt.blink_ticks = '0;
            end
         end
         tplc_pkg::LAMP_LIT, tplc_pkg::LAMP_DARK: begin
            if (!nxt.fault_flag) begin
               nxt.lamp_phase  = tplc_pkg::LAMP_IDLE;
               nxt.blink_ticks = '0;
            end else if (nxt.blink_ticks >= blink_period) begin
               nxt.lamp_phase  = (cur.lamp_phase == tplc_pkg::LAMP_LIT) ?
                                 tplc_pkg::LAMP_DARK : tplc_pkg::LAMP_LIT;
               nxt.blink_ticks = '0;
            end
         end
         default: begin
            nxt.lamp_phase  = tplc_pkg::LAMP_LIT;
            nxt.blink_ticks = '0;
         end
      endcase
   end

   assign pump_drive    = (nxt.pump_mode == tplc_pkg::MODE_ON);
   assign error_lamp    = (nxt.lamp_phase == tplc_pkg::LAMP_LIT);
   assign mode          = nxt.pump_mode;
   assign fault_latched = nxt.fault_flag;

endmodule

// ----- design/tank_pump_level_controller.sv -----
// Tank pump level controller. Each req transaction is one tick carrying the two
// sensor samples; each tick yields exactly one rsp transaction with the pump
// drive, error lamp, mode and latched fault. The lower sensor edge, else the
// upper sensor edge, else guard timer expiry forms the tick's event; a tick is
// processed by combinational next-state logic between the state registers and
// the result register, so one transaction is taken every cycle while rsp is
// not stalled. The result register frees as it is taken, so req_ready stays
// high through back-to-back traffic. The guard_timeout and blink_period
// registers are written through the csr port; the user must write them only
// while the block is idle, which the block itself does not enforce. A sensor error latches until reset.
module tank_pump_level_controller (
   input  logic        clock,
   input  logic        reset,
   // tick input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_below_low_mark,
   input  logic        req_above_high_mark,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_pump_drive,
   output logic        rsp_error_lamp,
   output logic [1:0]  rsp_mode,
   output logic        rsp_fault_latched,
   // configuration
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   tplc_pkg::ctrl_state_type state_ff, state_in;
   logic [tplc_pkg::TICK_W-1:0] guard_timeout_ff, blink_period_ff;
   logic       rsp_valid_ff;
   logic       pump_drive_ff, error_lamp_ff, fault_latched_ff;
   logic [1:0] mode_ff;
   logic       pump_drive_in, error_lamp_in, fault_latched_in;
   logic [1:0] mode_in;
   logic       req_take;

   // take a new tick when the result register is empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   tplc_step u_step (
      .cur             (state_ff),
      .below_low_mark  (req_below_low_mark),
      .above_high_mark (req_above_high_mark),
      .guard_timeout   (guard_timeout_ff),
      .blink_period    (blink_period_ff),
      .nxt             (state_in),
      .pump_drive      (pump_drive_in),
      .error_lamp      (error_lamp_in),
      .mode            (mode_in),
      .fault_latched   (fault_latched_in)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         guard_timeout_ff <= tplc_pkg::GUARD_TIMEOUT_RST;
         blink_period_ff  <= tplc_pkg::BLINK_PERIOD_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            tplc_pkg::CSR_GUARD_TIMEOUT: guard_timeout_ff <= csr_wdata;
            tplc_pkg::CSR_BLINK_PERIOD:  blink_period_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // controller state, advanced once per accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.pump_mode       <= tplc_pkg::MODE_OFF;
         state_ff.fault_flag      <= 1'b0;
         state_ff.prev_below_low  <= 1'b0;
         state_ff.prev_above_high <= 1'b0;
         state_ff.guard_armed     <= 1'b0;
         state_ff.guard_ticks     <= '0;
         state_ff.lamp_phase      <= tplc_pkg::LAMP_IDLE;
         state_ff.blink_ticks     <= '0;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   // result register: hold while stalled, drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         pump_drive_ff    <= pump_drive_in;
         error_lamp_ff    <= error_lamp_in;
         mode_ff          <= mode_in;
         fault_latched_ff <= fault_latched_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pump_drive    = pump_drive_ff;
   assign rsp_error_lamp    = error_lamp_ff;
   assign rsp_mode          = mode_ff;
   assign rsp_fault_latched = fault_latched_ff;

endmodule
